>>> rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants and payload types for the LRU page replacement core.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int NUM_FRAMES = 4;
    localparam int PAGE_BITS  = 16;
    localparam int IDX_W      = $clog2(NUM_FRAMES);
    localparam int RANK_W     = $clog2(NUM_FRAMES);
    localparam int FILL_W     = $clog2(NUM_FRAMES + 1);
    localparam int CFG_W      = 3;
    localparam int CNT_W      = 32;

    localparam logic [CFG_W-1:0] FRAMES_USED_RESET = CFG_W'(2);

    typedef struct packed {
        logic [PAGE_BITS-1:0] page_number;
        logic                 start_req;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic [IDX_W-1:0]     frame_index;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [CNT_W-1:0]     miss_count;
    } t_out_item;

    // Request from the control stage to the frame table
    typedef struct packed {
        logic                 step;
        logic                 start;
        logic [PAGE_BITS-1:0] page;
        logic [FILL_W-1:0]    limit;
    } t_frame_req;

    // Lookup outcome for the item held in the input register
    typedef struct packed {
        logic                 hit;
        logic [IDX_W-1:0]     frame_index;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
    } t_frame_res;

endpackage

>>> rtl/lrupr_frames.sv
// ----------------------------------------------------------------------------
// lrupr_frames
// Frame table: page numbers, recency ranks and fill count, with a parallel
// lookup and a registered rank update when the item steps.
// ----------------------------------------------------------------------------
module lrupr_frames (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrupr_pkg::t_frame_req i_req,
    output lrupr_pkg::t_frame_res o_res
);
    import lrupr_pkg::*;

    logic [PAGE_BITS-1:0] r_page [NUM_FRAMES];
    logic [RANK_W-1:0]    r_rank [NUM_FRAMES];
    logic [FILL_W-1:0]    r_fill;

    logic [RANK_W-1:0]    n_rank [NUM_FRAMES];
    logic [FILL_W-1:0]    n_fill;

    logic [FILL_W-1:0]    fill_eff;
    logic [RANK_W-1:0]    rank_eff [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] occ;
    logic [NUM_FRAMES-1:0] occ_new;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     best_idx;
    logic                 do_fill;
    logic [IDX_W-1:0]     sel_idx;

    // A start request empties the table ahead of this reference
    always_comb begin
        fill_eff = i_req.start ? '0 : r_fill;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            rank_eff[i] = i_req.start ? '0 : r_rank[i];
            occ[i]      = FILL_W'(i) < fill_eff;
        end
    end

    // First occupied frame holding the page
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (occ[i] && (r_page[i] == i_req.page)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Least recently used occupied frame; lowest index wins a tie
    always_comb begin
        best_idx = '0;
        for (int i = 1; i < NUM_FRAMES; i++) begin
            if (occ[i] && (rank_eff[i] > rank_eff[best_idx])) begin
                best_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        do_fill = !hit && (fill_eff < i_req.limit);
        if (hit) begin
            sel_idx = hit_idx;
        end else if (do_fill) begin
            sel_idx = fill_eff[IDX_W-1:0];
        end else begin
            sel_idx = best_idx;
        end
        n_fill = do_fill ? fill_eff + FILL_W'(1) : fill_eff;

        for (int i = 0; i < NUM_FRAMES; i++) begin
            occ_new[i] = FILL_W'(i) < n_fill;
            n_rank[i]  = rank_eff[i];
            if (hit) begin
                if (occ[i] && (rank_eff[i] < rank_eff[hit_idx])) begin
                    n_rank[i] = rank_eff[i] + RANK_W'(1);
                end
            end else if (occ_new[i]) begin
                n_rank[i] = rank_eff[i] + RANK_W'(1);
            end
            if (IDX_W'(i) == sel_idx) begin
                n_rank[i] = '0;
            end
        end
    end

    always_comb begin
        o_res.hit           = hit;
        o_res.frame_index   = sel_idx;
        o_res.evicted_valid = !hit && !do_fill;
        o_res.evicted_page  = (!hit && !do_fill) ? r_page[best_idx] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_req.step) begin
            r_fill <= n_fill;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // Page store has no reset: only occupied frames are ever compared or read
    always_ff @(posedge i_clk) begin
        if (i_req.step && !hit) begin
            r_page[sel_idx] <= i_req.page;
        end
    end

endmodule

>>> rtl/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement over a small frame set, one page reference per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries a page
//   number and a start flag that empties the frames and miss count first.
//   Output channel (o_out_valid / i_out_stall / o_out_item) returns one
//   result per reference: hit flag, frame used, evicted page and the
//   saturating miss count after that reference.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   frames_used; write only while no item is in flight.
//   The path from input accept to result valid is an input
//   register, then the lookup and rank update into the result register.
//   Throughput is one item per cycle while the output does not stall,
//   set by the parallel compare and rank update over the frame table.
//   Reset empties all frames, clears the miss count and sets frames_used
//   to 2. A stall on the output holds the result register and, once the
//   input register is also full, raises o_in_stall.
// ----------------------------------------------------------------------------
module lru_page_replacement_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  lrupr_pkg::t_in_item     i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output lrupr_pkg::t_out_item    o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0] i_cfg_data
);
    import lrupr_pkg::*;

    logic [CFG_W-1:0] r_frames_used;
    logic             r_in_valid;
    t_in_item         r_in;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] n_misses;

    logic             advance;
    logic             step;
    logic [FILL_W-1:0] limit;
    t_frame_req       frame_req;
    t_frame_res       frame_res;

    assign advance     = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Clamp frames_used into 1 .. NUM_FRAMES
    always_comb begin
        if (r_frames_used == '0) begin
            limit = FILL_W'(1);
        end else if (FILL_W'(r_frames_used) > FILL_W'(NUM_FRAMES)) begin
            limit = FILL_W'(NUM_FRAMES);
        end else begin
            limit = FILL_W'(r_frames_used);
        end
    end

    always_comb begin
        frame_req.step  = step;
        frame_req.start = r_in.start_req;
        frame_req.page  = r_in.page_number;
        frame_req.limit = limit;
    end

    lrupr_frames u_frames (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (frame_req),
        .o_res   (frame_res)
    );

    // Saturating miss count, cleared by a start request
    always_comb begin
        n_misses = r_in.start_req ? '0 : r_misses;
        if (!frame_res.hit && (n_misses != '1)) begin
            n_misses = n_misses + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_used <= FRAMES_USED_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_misses      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_frames_used <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_misses <= n_misses;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (step) begin
            r_out.hit           <= frame_res.hit;
            r_out.frame_index   <= frame_res.frame_index;
            r_out.evicted_valid <= frame_res.evicted_valid;
            r_out.evicted_page  <= frame_res.evicted_page;
            r_out.miss_count    <= n_misses;
        end
    end

endmodule

>>> rtl/lrupr_checker.sv
// ----------------------------------------------------------------------------
// lrupr_checker
// Port-level checks on the LRU page replacement core, bound to the top level.
// ----------------------------------------------------------------------------
module lrupr_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  lrupr_pkg::t_out_item o_out_item
);
    import lrupr_pkg::*;

    logic             out_acc;
    logic             r_seen;
    logic [CNT_W-1:0] r_last_cnt;

    assign out_acc = o_out_valid && !i_out_stall;

    // Remember the miss count of the last delivered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_acc) begin
            r_seen <= 1'b1;
        end
        if (out_acc) begin
            r_last_cnt <= o_out_item.miss_count;
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> !(o_out_item.hit && o_out_item.evicted_valid)
                    && (o_out_item.evicted_valid || o_out_item.evicted_page == '0))
        else $error("inconsistent hit and eviction fields");

    a_hit_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen && o_out_item.hit |-> o_out_item.miss_count == r_last_cnt)
        else $error("miss count moved on a hit");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
